FILE: hdl/chacha_pkg.sv
// ----------------------------------------------------------------------------
// ChaCha20 shared definitions
// Payload types, register indexes, sizing constants and round helpers used
// by the ChaCha20 stream cipher core.
// ----------------------------------------------------------------------------
package chacha_pkg;

    // Sizing defaults
    localparam int DOUBLE_ROUNDS_DEF = 10;
    localparam int FIFO_DEPTH_DEF    = 4;
    localparam int BLOCK_WORDS       = 16;
    localparam int BLOCK_BITS        = 512;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = 64;

    // Constant words "expand 32-byte k"
    localparam logic [31:0] SIGMA0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY_01   = 3'd0,
        REG_KEY_23   = 3'd1,
        REG_KEY_45   = 3'd2,
        REG_KEY_67   = 3'd3,
        REG_NONCE_01 = 3'd4,
        REG_NONCE_2  = 3'd5,
        REG_INIT_CTR = 3'd6
    } cfg_reg_t;

    // Generator states
    typedef enum logic [1:0] {
        GEN_IDLE,
        GEN_RUN,
        GEN_FIN
    } gen_state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_out;
        logic       counter_wrapped;
    } out_item_t;

    typedef struct packed {
        logic [255:0] key;
        logic [95:0]  nonce;
    } cipher_cfg_t;

    typedef struct packed {
        logic valid;
        logic wrapped;
    } ks_status_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } quad_t;

    // Half of a quarter round: rotations 16/12 first, then 8/7
    function automatic quad_t qr_half(input quad_t q, input logic second);
        quad_t       r;
        logic [31:0] ta;
        logic [31:0] td;
        logic [31:0] tc;
        logic [31:0] tb;
        ta = q.a + q.b;
        td = q.d ^ ta;
        if (second) begin
            td = {td[23:0], td[31:24]};
        end else begin
            td = {td[15:0], td[31:16]};
        end
        tc = q.c + td;
        tb = q.b ^ tc;
        if (second) begin
            tb = {tb[24:0], tb[31:25]};
        end else begin
            tb = {tb[19:0], tb[31:20]};
        end
        r.a = ta;
        r.b = tb;
        r.c = tc;
        r.d = td;
        return r;
    endfunction

    // Initial block state, word i at bits 32*i
    function automatic logic [BLOCK_BITS-1:0] init_block(input cipher_cfg_t cfg,
                                                         input logic [31:0] ctr);
        return {cfg.nonce, ctr, cfg.key, SIGMA3, SIGMA2, SIGMA1, SIGMA0};
    endfunction

endpackage

FILE: hdl/chacha20_stream_cipher_core.sv
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher core
// Encrypts or decrypts one byte per transaction with the ChaCha20 keystream.
//
//   channel  ports                      width  role
//   s_       s_valid s_ready s_data     9      byte and last mark in
//   m_       m_valid m_ready m_data     10     byte, last mark, wrap flag out
//   cfg_     cfg_valid cfg_ready        3+64   register index and data
//
// One byte per cycle sustained while the output accepts it; a fresh block is
// made in the round engine while the previous block is being used.
// After reset or a register write the first byte waits for that first block.
// Input and output stall independently through the input queue.
// Reset is synchronous; there is no clearing pass.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_core #(
    parameter int DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF,
    parameter int FIFO_DEPTH    = chacha_pkg::FIFO_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  chacha_pkg::in_item_t               s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output chacha_pkg::out_item_t              m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [chacha_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [chacha_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    logic [63:0] key_reg [4];
    logic [63:0] nonce01_reg;
    logic [31:0] nonce2_reg;
    logic [31:0] init_ctr_reg;
    logic        cfg_wr;
    logic        restart;
    logic [31:0] ctr_init;

    chacha_pkg::cipher_cfg_t cfg;
    chacha_pkg::in_item_t    q_data;
    chacha_pkg::ks_status_t  ks_stat;
    logic                    q_valid;
    logic                    q_pop;
    logic                    ks_pop;
    logic [chacha_pkg::BLOCK_BITS-1:0] ks_data;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // Restart on any write to a known register
    always_comb begin
        restart  = 1'b0;
        ctr_init = init_ctr_reg;
        if (cfg_wr) begin
            unique case (cfg_index)
                chacha_pkg::REG_KEY_01,
                chacha_pkg::REG_KEY_23,
                chacha_pkg::REG_KEY_45,
                chacha_pkg::REG_KEY_67,
                chacha_pkg::REG_NONCE_01,
                chacha_pkg::REG_NONCE_2: begin
                    restart = 1'b1;
                end
                chacha_pkg::REG_INIT_CTR: begin
                    restart  = 1'b1;
                    ctr_init = cfg_wdata[31:0];
                end
                default: begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                key_reg[i] <= '0;
            end
            nonce01_reg  <= '0;
            nonce2_reg   <= '0;
            init_ctr_reg <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                chacha_pkg::REG_KEY_01:   key_reg[0]   <= cfg_wdata;
                chacha_pkg::REG_KEY_23:   key_reg[1]   <= cfg_wdata;
                chacha_pkg::REG_KEY_45:   key_reg[2]   <= cfg_wdata;
                chacha_pkg::REG_KEY_67:   key_reg[3]   <= cfg_wdata;
                chacha_pkg::REG_NONCE_01: nonce01_reg  <= cfg_wdata;
                chacha_pkg::REG_NONCE_2:  nonce2_reg   <= cfg_wdata[31:0];
                chacha_pkg::REG_INIT_CTR: init_ctr_reg <= cfg_wdata[31:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.key   = {key_reg[3], key_reg[2], key_reg[1], key_reg[0]};
    assign cfg.nonce = {nonce2_reg, nonce01_reg};

    chacha_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_data  (q_data)
    );

    chacha_ksgen #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_ksgen (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .restart  (restart),
        .ctr_init (ctr_init),
        .cfg      (cfg),
        .ks_pop   (ks_pop),
        .ks_data  (ks_data),
        .ks_stat  (ks_stat)
    );

    chacha_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (restart),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_data  (q_data),
        .ks_data (ks_data),
        .ks_stat (ks_stat),
        .ks_pop  (ks_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: hdl/chacha_fifo.sv
// ----------------------------------------------------------------------------
// ChaCha20 input queue
// Front end: accepts input transactions and holds them until the back end
// has keystream to apply.
// ----------------------------------------------------------------------------
module chacha_fifo #(
    parameter int DEPTH = chacha_pkg::FIFO_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  chacha_pkg::in_item_t s_data,
    output logic                 q_valid,
    input  logic                 q_pop,
    output chacha_pkg::in_item_t q_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    chacha_pkg::in_item_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push;

    assign s_ready = (count_reg != CW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;

    // Store accepted transactions
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= s_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !q_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!push && q_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

endmodule

FILE: hdl/chacha_ksgen.sv
// ----------------------------------------------------------------------------
// ChaCha20 keystream generator
// Runs the block function one half quarter round per lane per cycle while a
// buffer slot is free, filling a two-slot block buffer ahead of the consumer.
// ----------------------------------------------------------------------------
module chacha_ksgen #(
    parameter int DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            restart,
    input  logic [31:0]                     ctr_init,
    input  chacha_pkg::cipher_cfg_t         cfg,
    input  logic                            ks_pop,
    output logic [chacha_pkg::BLOCK_BITS-1:0] ks_data,
    output chacha_pkg::ks_status_t          ks_stat
);

    localparam int HALF_STEPS = DOUBLE_ROUNDS * 4;
    localparam int HW         = $clog2(HALF_STEPS);
    localparam int NW         = chacha_pkg::BLOCK_WORDS;

    chacha_pkg::gen_state_t state_reg;
    chacha_pkg::gen_state_t state_next;

    logic [31:0] x_reg  [NW];
    logic [31:0] x_next [NW];
    logic [HW-1:0] half_reg;
    logic [chacha_pkg::BLOCK_BITS-1:0] blk_reg [2];
    logic [1:0]  blk_vld_reg;
    logic [1:0]  blk_wrap_reg;
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [31:0] ctr_reg;
    logic        wrap_reg;
    logic [chacha_pkg::BLOCK_BITS-1:0] init_w;
    logic [chacha_pkg::BLOCK_BITS-1:0] final_w;
    logic        start;
    logic        half_last;

    assign init_w    = chacha_pkg::init_block(cfg, ctr_reg);
    assign half_last = (half_reg == HW'(HALF_STEPS - 1));
    assign ks_data   = blk_reg[rd_ptr_reg];
    assign ks_stat.valid   = blk_vld_reg[rd_ptr_reg];
    assign ks_stat.wrapped = blk_wrap_reg[rd_ptr_reg];

    // One half quarter round on all four lanes, column or diagonal
    always_comb begin
        chacha_pkg::quad_t q;
        chacha_pkg::quad_t r;
        int ib;
        int ic;
        int id;
        logic diag;
        diag = half_reg[1];
        for (int w = 0; w < NW; w++) begin
            x_next[w] = x_reg[w];
        end
        for (int l = 0; l < 4; l++) begin
            ib = diag ? 4 + ((l + 1) % 4)  : 4 + l;
            ic = diag ? 8 + ((l + 2) % 4)  : 8 + l;
            id = diag ? 12 + ((l + 3) % 4) : 12 + l;
            q.a = x_reg[l];
            q.b = x_reg[ib];
            q.c = x_reg[ic];
            q.d = x_reg[id];
            r = chacha_pkg::qr_half(q, half_reg[0]);
            x_next[l]  = r.a;
            x_next[ib] = r.b;
            x_next[ic] = r.c;
            x_next[id] = r.d;
        end
    end

    // Feed-forward add of the initial state
    always_comb begin
        for (int w = 0; w < NW; w++) begin
            final_w[32*w +: 32] = x_reg[w] + init_w[32*w +: 32];
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        start      = 1'b0;
        unique case (state_reg)
            chacha_pkg::GEN_IDLE: begin
                if (!blk_vld_reg[wr_ptr_reg]) begin
                    start      = 1'b1;
                    state_next = chacha_pkg::GEN_RUN;
                end
            end
            chacha_pkg::GEN_RUN: begin
                if (half_last) begin
                    state_next = chacha_pkg::GEN_FIN;
                end
            end
            chacha_pkg::GEN_FIN: begin
                state_next = chacha_pkg::GEN_IDLE;
            end
            default: begin
                state_next = chacha_pkg::GEN_IDLE;
            end
        endcase
        if (restart) begin
            start      = 1'b0;
            state_next = chacha_pkg::GEN_IDLE;
        end
    end

    // State register and round counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= chacha_pkg::GEN_IDLE;
            half_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (start || restart) begin
                half_reg <= '0;
            end else if (state_reg == chacha_pkg::GEN_RUN) begin
                half_reg <= half_reg + 1'b1;
            end
        end
    end

    // Working state
    always_ff @(posedge aclk) begin
        if (start) begin
            for (int w = 0; w < NW; w++) begin
                x_reg[w] <= init_w[32*w +: 32];
            end
        end else if (state_reg == chacha_pkg::GEN_RUN) begin
            x_reg <= x_next;
        end
    end

    // Block buffer data
    always_ff @(posedge aclk) begin
        if (state_reg == chacha_pkg::GEN_FIN) begin
            blk_reg[wr_ptr_reg] <= final_w;
        end
    end

    // Block buffer control, counter and wrap flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_vld_reg  <= '0;
            blk_wrap_reg <= '0;
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            ctr_reg      <= '0;
            wrap_reg     <= 1'b0;
        end else if (restart) begin
            blk_vld_reg  <= '0;
            blk_wrap_reg <= '0;
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            ctr_reg      <= ctr_init;
            wrap_reg     <= 1'b0;
        end else begin
            if (state_reg == chacha_pkg::GEN_FIN) begin
                blk_vld_reg[wr_ptr_reg]  <= 1'b1;
                blk_wrap_reg[wr_ptr_reg] <= wrap_reg || (ctr_reg == '1);
                wr_ptr_reg <= !wr_ptr_reg;
                ctr_reg    <= ctr_reg + 1'b1;
                wrap_reg   <= wrap_reg || (ctr_reg == '1);
            end
            if (ks_pop) begin
                blk_vld_reg[rd_ptr_reg] <= 1'b0;
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        restart |=> (blk_vld_reg == 2'b00) && (state_reg == chacha_pkg::GEN_IDLE))
        else $error("restart left keystream state behind");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == chacha_pkg::GEN_RUN) && half_last && !restart
        |=> state_reg == chacha_pkg::GEN_FIN)
        else $error("round engine overran its last step");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ks_pop |-> ks_stat.valid)
        else $error("keystream block released while empty");

endmodule

FILE: hdl/chacha_back.sv
// ----------------------------------------------------------------------------
// ChaCha20 back end
// Applies one keystream byte to each queued transaction and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module chacha_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              restart,
    input  logic                              q_valid,
    output logic                              q_pop,
    input  chacha_pkg::in_item_t              q_data,
    input  logic [chacha_pkg::BLOCK_BITS-1:0] ks_data,
    input  chacha_pkg::ks_status_t            ks_stat,
    output logic                              ks_pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output chacha_pkg::out_item_t             m_data
);

    logic [5:0]            pos_reg;
    logic                  m_valid_reg;
    chacha_pkg::out_item_t m_data_reg;
    logic [7:0]            ks_byte;

    assign q_pop   = q_valid && ks_stat.valid && (!m_valid_reg || m_ready);
    assign ks_pop  = q_pop && (pos_reg == 6'h3f);
    assign ks_byte = ks_data[{pos_reg, 3'b000} +: 8];
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Result payload
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_data_reg.out_byte        <= q_data.data_byte ^ ks_byte;
            m_data_reg.last_out        <= q_data.last_byte;
            m_data_reg.counter_wrapped <= ks_stat.wrapped;
        end
    end

    // Byte position and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (restart) begin
                pos_reg <= '0;
            end else if (q_pop) begin
                pos_reg <= pos_reg + 1'b1;
            end
            if (q_pop) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        ks_pop && !restart |=> pos_reg == '0)
        else $error("byte position not rewound at block end");

endmodule
